/* design/lfgr_pkg.sv */
// lfgr_pkg: shared types and constants for the linear fade gain ramp unit
// used by lfgr_scale and linear_fade_gain_ramp_unit; no dependencies
package lfgr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 40;
  localparam int COUNT_W   = 32;
  localparam int CHCOUNT_W = 2;
  localparam int FRAC_BITS = 38;
  localparam int SPLIT_W   = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 40;

  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 40'h40_0000_0000;
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = 40'hFF_FFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_START    = 3'd0,
    REG_FADE_END      = 3'd1,
    REG_BEGIN_GAIN    = 3'd2,
    REG_GAIN_STEP     = 3'd3,
    REG_CHANNEL_COUNT = 3'd4
  } cfg_reg_t;

  // stage load enables shared by the datapath lanes
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } pipe_ctrl_t;

endpackage

/* design/lfgr_scale.sv */
// lfgr_scale: one channel lane, sample times gain with rounding and saturation
// two register stages (split partial products, then result); uses lfgr_pkg
module lfgr_scale (
  input  logic                                    clk,
  input  lfgr_pkg::pipe_ctrl_t                    ctrl,
  input  logic signed [lfgr_pkg::SAMPLE_W-1:0]    sample,
  input  logic        [lfgr_pkg::GAIN_W-1:0]      gain,
  output logic signed [lfgr_pkg::SAMPLE_W-1:0]    result
);
  import lfgr_pkg::*;

  localparam int MAG_W  = SAMPLE_W;
  localparam int HI_W   = GAIN_W - SPLIT_W;
  localparam int PP_W   = MAG_W + SPLIT_W;
  localparam int PH_W   = MAG_W + HI_W;
  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int R_W    = PROD_W - FRAC_BITS;

  localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [R_W-1:0]    POS_LIMIT  = R_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic [R_W-1:0]    NEG_LIMIT  = R_W'(1 << (SAMPLE_W - 1));
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PH_W-1:0]   prod_hi;
  logic [PP_W-1:0]   prod_lo;
  logic              neg_mul;
  logic [PROD_W-1:0] prod;
  logic [R_W-1:0]    rounded;
  logic signed [SAMPLE_W-1:0] result_next;

  always_comb begin
    neg = sample[SAMPLE_W-1];
    mag = neg ? (~sample + 1'b1) : sample;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_mul) begin
      prod_hi <= PH_W'(mag) * PH_W'(gain[GAIN_W-1:SPLIT_W]);
      prod_lo <= PP_W'(mag) * PP_W'(gain[SPLIT_W-1:0]);
      neg_mul <= neg;
    end
  end

  always_comb begin
    prod    = ({PROD_W'(prod_hi)} << SPLIT_W) + PROD_W'(prod_lo) + ROUND_BIAS;
    rounded = prod[PROD_W-1:FRAC_BITS];
    if (neg_mul) begin
      result_next = (rounded > NEG_LIMIT) ? S_MIN : -$signed(rounded[SAMPLE_W-1:0]);
    end else begin
      result_next = (rounded > POS_LIMIT) ? S_MAX : $signed(rounded[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      result <= result_next;
    end
  end

endmodule

/* design/linear_fade_gain_ramp_unit.sv */
// linear_fade_gain_ramp_unit: top level of the linear gain ramp (fade) block
// depends on lfgr_pkg and lfgr_scale
//
// usage:
//   input channel  in_valid/in_ready carries one stereo frame per item
//   (left_sample, right_sample, signed Q1.23); output channel
//   out_valid/out_ready returns the faded frame and ramp_active.
//   configuration is a write-only port (cfg_we, cfg_index, cfg_data); any
//   write to a listed register restarts the frame counter and reloads the
//   running gain from begin_gain. write only while the block is idle.
// pipeline: an accepted item passes the input register, the partial product
//   register and the result register before out_valid rises.
// throughput: one item per cycle unless stalled; the gain and frame counter
//   update in the cycle the item is accepted, and each 24x40 product is
//   split into two 24x20 multiplies so the three stages run back to back.
// reset: rst (synchronous) empties the pipeline and loads the register
//   defaults: start 0, end 1, begin gain 1.0, step 0, two channels.
// stall: when out_ready is low a stage holds while it and every later
//   stage are full; in_ready stays high as long as any stage has room.
module linear_fade_gain_ramp_unit #(
  parameter int CHANNELS = 2
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [lfgr_pkg::SAMPLE_W-1:0]    left_sample,
  input  logic signed [lfgr_pkg::SAMPLE_W-1:0]    right_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [lfgr_pkg::SAMPLE_W-1:0]    left_out,
  output logic signed [lfgr_pkg::SAMPLE_W-1:0]    right_out,
  output logic                                    ramp_active,
  input  logic                                    cfg_we,
  input  logic        [lfgr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic        [lfgr_pkg::CFG_W-1:0]       cfg_data
);
  import lfgr_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0]   fade_start;
  logic [COUNT_W-1:0]   fade_end;
  logic [GAIN_W-1:0]    begin_gain;
  logic [GAIN_W-1:0]    gain_step;
  logic [CHCOUNT_W-1:0] channel_count;

  // ramp state
  logic [COUNT_W-1:0]   frame_count;
  logic [COUNT_W-1:0]   frame_count_next;
  logic [GAIN_W-1:0]    gain;
  logic [GAIN_W-1:0]    gain_next;

  // pipeline
  logic       valid_in, valid_mul, valid_out;
  logic       active_in, active_mul;
  logic       load_in;
  pipe_ctrl_t ctrl;
  logic signed [SAMPLE_W-1:0] left_reg, right_reg;
  logic [GAIN_W-1:0]          gain_reg;

  logic                 accept;
  logic                 cfg_hit;
  logic                 window_empty;
  logic                 active;
  logic [GAIN_W-1:0]    gain_used;
  logic                 stereo;
  logic signed [GAIN_W+1:0] gain_sum;

  always_comb begin
    ctrl.load_out = !valid_out || out_ready;
    ctrl.load_mul = !valid_mul || ctrl.load_out;
    load_in       = !valid_in || ctrl.load_mul;
    in_ready      = load_in;
    accept        = in_valid && in_ready;
    out_valid     = valid_out;
  end

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_FADE_START, REG_FADE_END, REG_BEGIN_GAIN,
      REG_GAIN_STEP, REG_CHANNEL_COUNT: cfg_hit = cfg_we;
      default:                          cfg_hit = 1'b0;
    endcase
  end

  always_comb begin
    window_empty = !(fade_start < fade_end);
    active       = !window_empty && (frame_count >= fade_start) && (frame_count < fade_end);
    gain_used    = window_empty ? begin_gain : gain;
    if (CHANNELS >= 2) begin
      stereo = (channel_count >= CHCOUNT_W'(2));
    end else begin
      stereo = 1'b0;
    end

    gain_sum = $signed({2'b00, gain_used}) + $signed({{2{gain_step[GAIN_W-1]}}, gain_step});
    if (!active) begin
      gain_next = gain_used;
    end else if (gain_sum[GAIN_W+1]) begin
      gain_next = '0;
    end else if (gain_sum[GAIN_W]) begin
      gain_next = GAIN_MAX;
    end else begin
      gain_next = gain_sum[GAIN_W-1:0];
    end

    frame_count_next = (frame_count == COUNT_MAX) ? frame_count : frame_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start    <= '0;
      fade_end      <= COUNT_W'(1);
      begin_gain    <= GAIN_ONE;
      gain_step     <= '0;
      channel_count <= CHCOUNT_W'(2);
      frame_count   <= '0;
      gain          <= GAIN_ONE;
    end else if (cfg_hit) begin
      case (cfg_reg_t'(cfg_index))
        REG_FADE_START:    fade_start    <= cfg_data[COUNT_W-1:0];
        REG_FADE_END:      fade_end      <= cfg_data[COUNT_W-1:0];
        REG_BEGIN_GAIN:    begin_gain    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_STEP:     gain_step     <= cfg_data[GAIN_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CHCOUNT_W-1:0];
        default:           fade_start    <= fade_start;
      endcase
      frame_count <= '0;
      gain <= (cfg_reg_t'(cfg_index) == REG_BEGIN_GAIN) ? cfg_data[GAIN_W-1:0] : begin_gain;
    end else if (accept) begin
      frame_count <= frame_count_next;
      gain        <= gain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_in    <= 1'b0;
      valid_mul   <= 1'b0;
      valid_out   <= 1'b0;
      active_in   <= 1'b0;
      active_mul  <= 1'b0;
      ramp_active <= 1'b0;
    end else begin
      if (load_in) begin
        valid_in  <= accept;
        active_in <= active;
      end
      if (ctrl.load_mul) begin
        valid_mul  <= valid_in;
        active_mul <= active_in;
      end
      if (ctrl.load_out) begin
        valid_out   <= valid_mul;
        ramp_active <= active_mul;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      left_reg  <= left_sample;
      right_reg <= stereo ? right_sample : '0;
      gain_reg  <= gain_used;
    end
  end

  lfgr_scale u_scale_left (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (left_reg),
    .gain   (gain_reg),
    .result (left_out)
  );

  lfgr_scale u_scale_right (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (right_reg),
    .gain   (gain_reg),
    .result (right_out)
  );

endmodule
